// ===== rtl/camel_to_snake_case_transducer_assert.svh =====
// assertion macros for the camel to snake case transducer
// depends on nothing; included by the modules that check their own logic
`ifndef CAMEL_TO_SNAKE_CASE_TRANSDUCER_ASSERT_SVH
`define CAMEL_TO_SNAKE_CASE_TRANSDUCER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// implication checked at every clock edge outside reset
`define C2S_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("c2s assertion failed");
// condition that must never be true outside reset
`define C2S_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("c2s forbidden condition seen");
`else
`define C2S_ASSERT(lbl, clk, rst_n, prop)
`define C2S_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/c2s_pkg.sv =====
// shared types and character constants of the camel to snake case transducer
// depends on nothing
`timescale 1ns / 1ps
package c2s_pkg;

	// scanner modes
	typedef enum logic [1:0] {
		MODE_PLAIN     = 2'd0,
		MODE_COLON     = 2'd1,
		MODE_RUN_END   = 2'd2,
		MODE_RUN_START = 2'd3
	} mode_t;

	localparam int unsigned CP_W    = 21;
	localparam int unsigned MAX_RES = 4;
	localparam int unsigned CNT_W   = 3;

	localparam logic [CP_W-1:0] CH_DASH  = 21'h2D;
	localparam logic [CP_W-1:0] CH_COLON = 21'h3A;
	localparam logic [CP_W-1:0] CH_SLASH = 21'h2F;
	localparam logic [CP_W-1:0] CH_UNDER = 21'h5F;
	localparam logic [CP_W-1:0] CH_UP_A  = 21'h41;
	localparam logic [CP_W-1:0] CH_UP_Z  = 21'h5A;
	localparam logic [CP_W-1:0] CH_LO_A  = 21'h61;
	localparam logic [CP_W-1:0] CH_LO_Z  = 21'h7A;
	localparam logic [CP_W-1:0] CH_DIG_0 = 21'h30;
	localparam logic [CP_W-1:0] CH_DIG_9 = 21'h39;

	// scanner state carried from item to item
	typedef struct packed {
		mode_t      mode;
		logic       after_word_char;
		logic [6:0] held_char;
	} state_t;

	// outcome of one item: next state and the list of result chars
	typedef struct packed {
		state_t                          st;
		logic [MAX_RES-1:0][CP_W-1:0]    ch;
		logic [CNT_W-1:0]                n;
	} step_t;

endpackage

// ===== rtl/c2s_in_if.sv =====
// input channel of the transducer: one codepoint per item
// depends on c2s_pkg
`timescale 1ns / 1ps
interface c2s_in_if;
	logic                         valid;
	logic                         ready;
	logic [c2s_pkg::CP_W-1:0]     code_point;
	logic                         string_end;

	modport source (output valid, output code_point, output string_end, input ready);
	modport sink (input valid, input code_point, input string_end, output ready);
endinterface

// ===== rtl/c2s_out_if.sv =====
// output channel of the transducer: one result codepoint per item
// depends on c2s_pkg
`timescale 1ns / 1ps
interface c2s_out_if;
	logic                         valid;
	logic                         ready;
	logic [c2s_pkg::CP_W-1:0]     out_char;
	logic                         run_last;
	logic                         text_last;

	modport source (output valid, output out_char, output run_last, output text_last,
		input ready);
	modport sink (input valid, input out_char, input run_last, input text_last,
		output ready);
endinterface

// ===== rtl/camel_to_snake_case_transducer.sv =====
// top level of the camel to snake case transducer: input register, rule
// logic, result list and output sequencer; depends on c2s_pkg, c2s_in_if,
// c2s_out_if, c2s_step and camel_to_snake_case_transducer_assert.svh
//
//  channel | dir | payload                          | one item
//  text    | in  | code_point[20:0], string_end     | one codepoint
//  snake   | out | out_char[20:0], run_last,        | one result codepoint
//          |     | text_last                        |
//
// an input item passes the input register and the rule logic into the result
// list; an item that yields k results holds the list until all k have been
// taken on the single output port, while the next item waits in the input
// register. an item with no result leaves the list free for the next one
// reset clears the scanner state, the input register and the result list
// a stall on snake holds the list; text stays ready while the input
// register is free or moves on into the list in the same cycle
`timescale 1ns / 1ps
`include "camel_to_snake_case_transducer_assert.svh"
module camel_to_snake_case_transducer (
	input  logic       clk,
	input  logic       arst_n,
	c2s_in_if.sink     text,
	c2s_out_if.source  snake
);

	logic                                              v_s1;
	logic [c2s_pkg::CP_W-1:0]                          cp_s1;
	logic                                              end_s1;
	c2s_pkg::state_t                                   state_q;
	c2s_pkg::step_t                                    res;
	logic [c2s_pkg::MAX_RES-1:0][c2s_pkg::CP_W-1:0]    ch_s2;
	logic                                              end_s2;
	logic [c2s_pkg::CNT_W-1:0]                         rem_q;
	logic [1:0]                                        idx_q;
	logic                                              fire;
	logic                                              list_free;
	logic                                              adv;

	// handshake glue
	assign fire      = snake.valid && snake.ready;
	assign list_free = (rem_q == '0) || ((rem_q == c2s_pkg::CNT_W'(1)) && snake.ready);
	assign adv       = v_s1 && list_free;
	assign text.ready = !v_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (text.ready) begin
			v_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			cp_s1  <= text.code_point;
			end_s1 <= text.string_end;
		end
	end

	// rule logic
	c2s_step u_step (
		.st         (state_q),
		.code_point (cp_s1),
		.string_end (end_s1),
		.res        (res)
	);

	// scanner state and result list control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			rem_q   <= '0;
			idx_q   <= '0;
		end else if (adv) begin
			state_q <= res.st;
			rem_q   <= res.n;
			idx_q   <= '0;
		end else if (fire) begin
			rem_q <= rem_q - c2s_pkg::CNT_W'(1);
			idx_q <= idx_q + 2'd1;
		end
	end

	// result list payload
	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s2  <= res.ch;
			end_s2 <= end_s1;
		end
	end

	// output sequencer
	assign snake.valid     = (rem_q != '0);
	assign snake.out_char  = ch_s2[idx_q];
	assign snake.run_last  = (rem_q == c2s_pkg::CNT_W'(1));
	assign snake.text_last = (rem_q == c2s_pkg::CNT_W'(1)) && end_s2;

	// an item with no result leaves the output idle
	`C2S_ASSERT(a_empty_item, clk, arst_n, (adv && (res.n == '0)) |=> !snake.valid)
	// the last result of a string is seen with the scanner back at reset
	`C2S_ASSERT(a_text_reset, clk, arst_n, (fire && snake.text_last) |-> (state_q == '0))
	// no item yields more than three results
	`C2S_NEVER(a_res_bound, clk, arst_n, rem_q > c2s_pkg::CNT_W'(3))
	// a held input item keeps its codepoint until it moves on
	`C2S_ASSERT(a_hold_s1, clk, arst_n, (v_s1 && !adv) |=> (v_s1 && $stable(cp_s1)))

endmodule

// ===== rtl/c2s_step.sv =====
// combinational rule logic: one codepoint and the scanner state in,
// up to three result chars and the next state out; depends on c2s_pkg
`timescale 1ns / 1ps
module c2s_step (
	input  c2s_pkg::state_t              st,
	input  logic [c2s_pkg::CP_W-1:0]     code_point,
	input  logic                         string_end,
	output c2s_pkg::step_t               res
);

	function automatic logic is_upper(input logic [c2s_pkg::CP_W-1:0] c);
		return (c >= c2s_pkg::CH_UP_A) && (c <= c2s_pkg::CH_UP_Z);
	endfunction

	function automatic logic is_lower(input logic [c2s_pkg::CP_W-1:0] c);
		return (c >= c2s_pkg::CH_LO_A) && (c <= c2s_pkg::CH_LO_Z);
	endfunction

	function automatic logic is_digit(input logic [c2s_pkg::CP_W-1:0] c);
		return (c >= c2s_pkg::CH_DIG_0) && (c <= c2s_pkg::CH_DIG_9);
	endfunction

	// append one char to the result list
	function automatic c2s_pkg::step_t put(input c2s_pkg::step_t a,
		input logic [c2s_pkg::CP_W-1:0] c);
		c2s_pkg::step_t r;
		r = a;
		if (r.n < c2s_pkg::CNT_W'(c2s_pkg::MAX_RES)) begin
			r.ch[r.n[1:0]] = c;
			r.n = r.n + c2s_pkg::CNT_W'(1);
		end
		return r;
	endfunction

	// emit with lowering and the underscore before a capital after a word char
	function automatic c2s_pkg::step_t emit(input c2s_pkg::step_t a,
		input logic [c2s_pkg::CP_W-1:0] c);
		c2s_pkg::step_t r;
		r = a;
		if (is_upper(c)) begin
			if (r.st.after_word_char) begin
				r.st.after_word_char = 1'b0;
				r = put(r, c2s_pkg::CH_UNDER);
			end
			r = put(r, c - c2s_pkg::CH_UP_A + c2s_pkg::CH_LO_A);
		end else begin
			r.st.after_word_char = is_lower(c) || is_digit(c);
			r = put(r, c);
		end
		return r;
	endfunction

	// handling of a char from plain mode
	function automatic c2s_pkg::step_t plain(input c2s_pkg::step_t a,
		input logic [c2s_pkg::CP_W-1:0] c);
		c2s_pkg::step_t r;
		r = a;
		r.st.mode = c2s_pkg::MODE_PLAIN;
		if (c == c2s_pkg::CH_DASH) begin
			r = emit(r, c2s_pkg::CH_UNDER);
		end else if (c == c2s_pkg::CH_COLON) begin
			r.st.mode = c2s_pkg::MODE_COLON;
		end else if (is_digit(c) || is_upper(c)) begin
			r.st.held_char = c[6:0];
			r.st.mode = c2s_pkg::MODE_RUN_START;
		end else begin
			r = emit(r, c);
		end
		return r;
	endfunction

	// one pass of the rules, then the end-of-string flush
	always_comb begin
		c2s_pkg::step_t a;
		logic [c2s_pkg::CP_W-1:0] held;
		a = '0;
		a.st = st;
		held = {14'd0, st.held_char};
		case (st.mode)
			c2s_pkg::MODE_COLON: begin
				if (code_point == c2s_pkg::CH_COLON) begin
					a = emit(a, c2s_pkg::CH_SLASH);
					a.st.mode = c2s_pkg::MODE_PLAIN;
				end else begin
					a = emit(a, c2s_pkg::CH_COLON);
					a = plain(a, code_point);
				end
			end
			c2s_pkg::MODE_RUN_START: begin
				a = emit(a, held);
				if (is_digit(code_point)) begin
					a.st.held_char = code_point[6:0];
				end else if (is_upper(code_point)) begin
					a.st.held_char = code_point[6:0];
					a.st.mode = c2s_pkg::MODE_RUN_END;
				end else begin
					a = plain(a, code_point);
				end
			end
			c2s_pkg::MODE_RUN_END: begin
				if (is_digit(code_point)) begin
					a = emit(a, held);
					a.st.held_char = code_point[6:0];
					a.st.mode = c2s_pkg::MODE_RUN_START;
				end else if (is_upper(code_point)) begin
					a = emit(a, held);
					a.st.held_char = code_point[6:0];
				end else if (is_lower(code_point)) begin
					a = emit(a, c2s_pkg::CH_UNDER);
					a = emit(a, held);
					a = plain(a, code_point);
				end else begin
					a = emit(a, held);
					a = plain(a, code_point);
				end
			end
			default: begin
				a = plain(a, code_point);
			end
		endcase
		if (string_end) begin
			if (a.st.mode == c2s_pkg::MODE_COLON) begin
				a = emit(a, c2s_pkg::CH_COLON);
			end else if ((a.st.mode == c2s_pkg::MODE_RUN_START) ||
				(a.st.mode == c2s_pkg::MODE_RUN_END)) begin
				a = emit(a, {14'd0, a.st.held_char});
			end
			a.st = '0;
		end
		res = a;
	end

endmodule

// ===== test/camel_to_snake_case_transducer_tb.sv =====
// testbench of camel_to_snake_case_transducer: sends directed and random strings,
// predicts the snake case items in a scoreboard class and checks every output item
// depends on c2s_pkg, c2s_in_if, c2s_out_if and the transducer rtl
`timescale 1ns / 1ps
module camel_to_snake_case_transducer_tb;

	localparam int RAND_ITEMS = 470;

	// one expected or observed output item
	typedef struct packed {
		logic [c2s_pkg::CP_W-1:0] ch;
		logic                     run_last;
		logic                     text_last;
	} snake_item_t;

	// scanner prediction and store of expected output items
	class snake_scoreboard;
		c2s_pkg::mode_t           mode;
		bit                       word_seen;
		bit [6:0]                 held;
		snake_item_t              pending[$];
		logic [c2s_pkg::CP_W-1:0] step_chars[$];
		int                       errors;

		function new();
			mode      = c2s_pkg::MODE_PLAIN;
			word_seen = 1'b0;
			held      = '0;
			errors    = 0;
		endfunction

		function bit is_upper(logic [c2s_pkg::CP_W-1:0] c);
			return c >= c2s_pkg::CH_UP_A && c <= c2s_pkg::CH_UP_Z;
		endfunction

		function bit is_lower(logic [c2s_pkg::CP_W-1:0] c);
			return c >= c2s_pkg::CH_LO_A && c <= c2s_pkg::CH_LO_Z;
		endfunction

		function bit is_digit(logic [c2s_pkg::CP_W-1:0] c);
			return c >= c2s_pkg::CH_DIG_0 && c <= c2s_pkg::CH_DIG_9;
		endfunction

		function void put_char(logic [c2s_pkg::CP_W-1:0] c);
			if (step_chars.size() < c2s_pkg::MAX_RES)
				step_chars.push_back(c);
		endfunction

		// lower a capital, with an underscore after a word char
		function void emit_char(logic [c2s_pkg::CP_W-1:0] c);
			if (is_upper(c)) begin
				if (word_seen) begin
					word_seen = 1'b0;
					put_char(c2s_pkg::CH_UNDER);
				end
				put_char(c - c2s_pkg::CH_UP_A + c2s_pkg::CH_LO_A);
				return;
			end
			word_seen = is_lower(c) || is_digit(c);
			put_char(c);
		endfunction

		function void emit_held();
			emit_char({{(c2s_pkg::CP_W-7){1'b0}}, held});
		endfunction

		// handling of a char with nothing pending
		function void plain_char(logic [c2s_pkg::CP_W-1:0] c);
			mode = c2s_pkg::MODE_PLAIN;
			if (c == c2s_pkg::CH_DASH) begin
				emit_char(c2s_pkg::CH_UNDER);
			end else if (c == c2s_pkg::CH_COLON) begin
				mode = c2s_pkg::MODE_COLON;
			end else if (is_digit(c) || is_upper(c)) begin
				held = c[6:0];
				mode = c2s_pkg::MODE_RUN_START;
			end else begin
				emit_char(c);
			end
		endfunction

		// accepted input item: work out its output items
		function void note_input(logic [c2s_pkg::CP_W-1:0] c, logic last);
			snake_item_t it;
			step_chars.delete();
			case (mode)
				c2s_pkg::MODE_COLON: begin
					if (c == c2s_pkg::CH_COLON) begin
						emit_char(c2s_pkg::CH_SLASH);
						mode = c2s_pkg::MODE_PLAIN;
					end else begin
						emit_char(c2s_pkg::CH_COLON);
						plain_char(c);
					end
				end
				c2s_pkg::MODE_RUN_START: begin
					emit_held();
					if (is_digit(c)) begin
						held = c[6:0];
					end else if (is_upper(c)) begin
						held = c[6:0];
						mode = c2s_pkg::MODE_RUN_END;
					end else begin
						plain_char(c);
					end
				end
				c2s_pkg::MODE_RUN_END: begin
					if (is_digit(c)) begin
						emit_held();
						held = c[6:0];
						mode = c2s_pkg::MODE_RUN_START;
					end else if (is_upper(c)) begin
						emit_held();
						held = c[6:0];
					end else if (is_lower(c)) begin
						emit_char(c2s_pkg::CH_UNDER);
						emit_held();
						plain_char(c);
					end else begin
						emit_held();
						plain_char(c);
					end
				end
				default: plain_char(c);
			endcase
			// string end flushes a pending colon or held char
			if (last) begin
				if (mode == c2s_pkg::MODE_COLON)
					emit_char(c2s_pkg::CH_COLON);
				else if (mode == c2s_pkg::MODE_RUN_START || mode == c2s_pkg::MODE_RUN_END)
					emit_held();
				mode      = c2s_pkg::MODE_PLAIN;
				word_seen = 1'b0;
				held      = '0;
			end
			foreach (step_chars[i]) begin
				it.ch        = step_chars[i];
				it.run_last  = (i == step_chars.size() - 1);
				it.text_last = last && (i == step_chars.size() - 1);
				pending.push_back(it);
			end
		endfunction

		// observed output item against the oldest expectation
		function void check_result(snake_item_t got);
			snake_item_t exp_item;
			if (pending.size() == 0) begin
				$display("%0t: unexpected item ch=%h run_last=%b text_last=%b",
					$time, got.ch, got.run_last, got.text_last);
				errors++;
				return;
			end
			exp_item = pending.pop_front();
			if (got.ch !== exp_item.ch || got.run_last !== exp_item.run_last ||
					got.text_last !== exp_item.text_last) begin
				$display("%0t: item error exp ch=%h run_last=%b text_last=%b",
					$time, exp_item.ch, exp_item.run_last, exp_item.text_last);
				$display("%0t:            got ch=%h run_last=%b text_last=%b",
					$time, got.ch, got.run_last, got.text_last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	c2s_in_if  text_if ();
	c2s_out_if snake_if ();

	camel_to_snake_case_transducer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.snake  (snake_if)
	);

	snake_scoreboard          sb = new();
	int                       send_idle = 32;
	int                       recv_idle = 52;
	logic [c2s_pkg::CP_W-1:0] text_buf[$];

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// one input item, held until accepted
	task automatic send_item(input logic [c2s_pkg::CP_W-1:0] cp, input logic last);
		while ($urandom_range(99) < send_idle) begin
			text_if.valid <= 1'b0;
			@(posedge clk);
		end
		text_if.valid      <= 1'b1;
		text_if.code_point <= cp;
		text_if.string_end <= last;
		@(posedge clk);
		while (!text_if.ready)
			@(posedge clk);
		sb.note_input(cp, last);
	endtask

	// the whole string in text_buf, end marked on its final char
	task automatic send_text();
		foreach (text_buf[i])
			send_item(text_buf[i], i == text_buf.size() - 1);
		text_buf.delete();
	endtask

	task automatic send_ascii(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(c2s_pkg::CP_W'(s[i]));
		send_text();
	endtask

	// random char, weighted toward letters, digits and the special marks
	function automatic logic [c2s_pkg::CP_W-1:0] rand_char();
		int pick;
		pick = $urandom_range(99);
		if (pick < 25)
			return c2s_pkg::CH_UP_A + c2s_pkg::CP_W'($urandom_range(25));
		else if (pick < 50)
			return c2s_pkg::CH_LO_A + c2s_pkg::CP_W'($urandom_range(25));
		else if (pick < 62)
			return c2s_pkg::CH_DIG_0 + c2s_pkg::CP_W'($urandom_range(9));
		else if (pick < 72)
			return c2s_pkg::CH_COLON;
		else if (pick < 77)
			return c2s_pkg::CH_DASH;
		else if (pick < 81)
			return c2s_pkg::CH_UNDER;
		else if (pick < 90)
			return c2s_pkg::CP_W'($urandom_range(127));
		else
			return c2s_pkg::CP_W'($urandom_range(21'h1FFFFF, 21'h80));
	endfunction

	// output side: random stalls, check on every accepted item
	initial begin
		snake_item_t got;
		snake_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			snake_if.ready <= ($urandom_range(99) >= recv_idle);
			@(posedge clk);
			if (snake_if.valid && snake_if.ready) begin
				got.ch        = snake_if.out_char;
				got.run_last  = snake_if.run_last;
				got.text_last = snake_if.text_last;
				sb.check_result(got);
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("camel_to_snake_case_transducer: mismatch");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int sent;
		int len;
		arst_n             = 1'b0;
		text_if.valid      = 1'b0;
		text_if.code_point = '0;
		text_if.string_end = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: camel hump, capital run before lower, colons, dash, digit run,
		// lone capital, colon flush, non ascii and out of range codepoints
		send_ascii("aB");
		send_ascii("ABc");
		send_ascii("a::b:");
		send_ascii("9Z-");
		send_ascii("A");
		send_ascii(":Ab");
		send_ascii("_Q");
		text_buf.push_back(21'h1FFFFF);
		text_buf.push_back(21'h000000);
		text_buf.push_back(21'h10FFFF);
		text_buf.push_back(c2s_pkg::CH_LO_Z);
		send_text();

		// random strings, idling phases swap by item count
		sent = 0;
		while (sent < RAND_ITEMS) begin
			if (sent < RAND_ITEMS / 3) begin
				send_idle = 32;
				recv_idle = 52;
			end else if (sent < 2 * RAND_ITEMS / 3) begin
				send_idle = 52;
				recv_idle = 32;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			len = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 2);
			repeat (len)
				text_buf.push_back(rand_char());
			sent += len;
			send_text();
		end
		text_if.valid <= 1'b0;

		// drain, then wait on to catch stray items
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.errors++;
		if (sb.errors == 0)
			$display("camel_to_snake_case_transducer: match");
		else
			$display("camel_to_snake_case_transducer: mismatch");
		$finish;
	end

endmodule
